>>> design/cipher_rotor_stage_unit_assert.svh
// ----------------------------------------------------------------------------
// Rotor stage assertion macros
// Shared concurrent assertion forms for the rotor stage RTL.
// ----------------------------------------------------------------------------
`ifndef CIPHER_ROTOR_STAGE_UNIT_ASSERT_SVH
`define CIPHER_ROTOR_STAGE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CRS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rotor stage assertion failed");

// Next-cycle implication.
`define CRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rotor stage assertion failed");

`endif

>>> design/crs_pkg.sv
// ----------------------------------------------------------------------------
// Rotor stage package
// Wheel wirings, notch sets, item and result types, and lookup functions.
// ----------------------------------------------------------------------------
`default_nettype none

package crs_pkg;

    localparam int ALPHA       = 26;
    localparam int WHEEL_COUNT = 9;

    localparam logic [7:0] ASCII_A = 8'h41;

    // Register index of wheel_select (paddr[2]).
    localparam logic CRS_REG_WHEEL_SELECT = 1'b0;

    typedef enum logic [1:0] {
        OP_ADVANCE = 2'd0,
        OP_FORWARD = 2'd1,
        OP_REVERSE = 2'd2,
        OP_LOAD    = 2'd3
    } crs_op_t;

    typedef struct packed {
        crs_op_t    opcode;
        logic [4:0] letter;
        logic [4:0] start_position;
    } crs_item_t;

    typedef struct packed {
        logic [4:0] letter_out;
        logic       carry;
    } crs_result_t;

    // First character sits in the top byte of each entry.
    localparam logic [8*ALPHA-1:0] WIRING [WHEEL_COUNT] = '{
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
        "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
        "AJDKSIRUXBLHWTMCQGZNPYFVOE",
        "BDFHJLCPRTXVZNYEIWGAKMUSQO",
        "ESOVPZJAYQUIRHXLNFTGKDCMWB",
        "VZBRGITYUPSDNHLXAWMJQOFECK",
        "JPGVOUMFYQBENHZRDKASXLICTW",
        "NZJHGRCXMYSWBOUFAIVLPEKQDT",
        "FKQHTLXOCBJSPDZRAMEWNIUYGV"
    };

    // Bit n set: letter n is a turnover notch.
    localparam logic [ALPHA-1:0] NOTCH [WHEEL_COUNT] = '{
        26'(1) << 0,
        26'(1) << 16,
        26'(1) << 4,
        26'(1) << 21,
        26'(1) << 9,
        26'(1) << 25,
        (26'(1) << 25) | (26'(1) << 12),
        (26'(1) << 25) | (26'(1) << 12),
        (26'(1) << 25) | (26'(1) << 12)
    };

    function automatic logic [4:0] fwd_map(input logic [3:0] wheel, input logic [4:0] idx);
        logic [7:0] ofs;
        logic [7:0] ch;
        ofs = {5'(ALPHA - 1) - idx, 3'b000};
        ch  = WIRING[wheel][ofs +: 8];
        return 5'(ch - ASCII_A);
    endfunction

    // Inverse wiring: match every contact in parallel, the wiring is a permutation.
    function automatic logic [4:0] rev_map(input logic [3:0] wheel, input logic [4:0] idx);
        logic [4:0] res;
        res = '0;
        for (int k = 0; k < ALPHA; k++) begin
            if (fwd_map(wheel, 5'(k)) == idx) begin
                res = 5'(k);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> design/cipher_rotor_stage_unit.sv
// ----------------------------------------------------------------------------
// Rotor cipher stage
// One wheel of a rotor cipher: advance, load, forward and reverse mapping.
//
//   Channel   Direction  Contents
//   s_        in         tuser: opcode; tdata: letter, start_position
//   m_        out        tdata: letter_out, carry
//   APB       in/out     wheel_select at byte address 0
//
// An item passes through the input register, then the result register; one item per cycle unless m_ stalls.
// The input register feeds the datapath; the result register holds its output.
// The wheel position is updated as an item moves into the result register.
// A stalled result blocks the input register only when both are full.
// Reset (synchronous, active low) clears position, wheel select and valids.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cipher_rotor_stage_unit_assert.svh"

module cipher_rotor_stage_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [4:0] letter, [9:5] start_position, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata    // [4:0] letter_out, [5] carry, rest zero
);

    logic                 in_valid_reg;
    crs_pkg::crs_item_t   in_item_reg;
    logic                 out_valid_reg;
    crs_pkg::crs_result_t out_result_reg;
    logic [4:0]           position_reg;
    logic [4:0]           position_next;
    logic [3:0]           wheel_select;
    crs_pkg::crs_result_t result;
    logic                 out_ready;
    logic                 step_fire;
    logic                 in_fire;

    crs_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .wheel_select (wheel_select)
    );

    crs_datapath u_dp (
        .wheel_select  (wheel_select),
        .position      (position_reg),
        .item          (in_item_reg),
        .result        (result),
        .position_next (position_next)
    );

    assign out_ready = !out_valid_reg || m_tready;
    assign step_fire = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            position_reg  <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
            if (step_fire) begin
                position_reg <= position_next;
            end
        end
    end

    // Payload: load on transfer, hold otherwise.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_item_reg.opcode         <= crs_pkg::crs_op_t'(s_tuser);
            in_item_reg.letter         <= s_tdata[4:0];
            in_item_reg.start_position <= s_tdata[9:5];
        end
        if (step_fire) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_result_reg.carry, out_result_reg.letter_out};

    `CRS_ASSERT_IMPLIES(a_pos_range, aclk, aresetn, 1'b1, position_reg < 5'(crs_pkg::ALPHA))
    `CRS_ASSERT_IMPLIES(a_letter_range, aclk, aresetn, m_tvalid, m_tdata[4:0] < 5'(crs_pkg::ALPHA))
    `CRS_ASSERT_IMPLIES(a_carry_alone, aclk, aresetn, m_tvalid && m_tdata[5], m_tdata[4:0] == 5'd0)
    `CRS_ASSERT_IMPLIES(a_ready_when_empty, aclk, aresetn, !out_valid_reg, s_tready)
    `CRS_ASSERT_NEXT(a_pos_hold, aclk, aresetn, !step_fire, $stable(position_reg))

endmodule

`default_nettype wire

>>> design/crs_cfg_regs.sv
// ----------------------------------------------------------------------------
// Rotor stage configuration registers
// APB slave holding the wheel select register.
// ----------------------------------------------------------------------------
`default_nettype none

module crs_cfg_regs (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [3:0]  wheel_select
);

    logic [3:0] wheel_select_reg;
    logic [3:0] wheel_select_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        wheel_select_next = wheel_select_reg;
        prdata            = '0;
        unique case (paddr[2])
            crs_pkg::CRS_REG_WHEEL_SELECT: begin
                prdata = {28'd0, wheel_select_reg};
                if (wr_en) begin
                    wheel_select_next = pwdata[3:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_select_reg <= '0;
        end else begin
            wheel_select_reg <= wheel_select_next;
        end
    end

    assign wheel_select = wheel_select_reg;

endmodule

`default_nettype wire

>>> design/crs_datapath.sv
// ----------------------------------------------------------------------------
// Rotor stage datapath
// Wiring lookup, notch test and modulo-26 position arithmetic for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module crs_datapath (
    input  wire logic [3:0]          wheel_select,
    input  wire logic [4:0]          position,
    input  wire crs_pkg::crs_item_t  item,
    output crs_pkg::crs_result_t     result,
    output logic [4:0]               position_next
);

    logic [3:0] wheel;
    logic [5:0] sum;
    logic [4:0] idx;
    logic [4:0] mapped;
    logic [5:0] diff;
    logic [4:0] out_letter;
    logic [4:0] start_mod;

    // Unused wheel numbers fall back to the identity wheel.
    assign wheel = (wheel_select <= 4'(crs_pkg::WHEEL_COUNT - 1)) ? wheel_select : 4'd0;

    // letter + position stays below 2*26 + 26, so at most two folds.
    assign sum = {1'b0, item.letter} + {1'b0, position};
    always_comb begin
        if (sum >= 6'(2 * crs_pkg::ALPHA)) begin
            idx = 5'(sum - 6'(2 * crs_pkg::ALPHA));
        end else if (sum >= 6'(crs_pkg::ALPHA)) begin
            idx = 5'(sum - 6'(crs_pkg::ALPHA));
        end else begin
            idx = 5'(sum);
        end
    end

    assign mapped = (item.opcode == crs_pkg::OP_FORWARD) ? crs_pkg::fwd_map(wheel, idx)
                                                        : crs_pkg::rev_map(wheel, idx);

    // Subtract the position back out, wrapping below zero.
    assign diff       = {1'b0, mapped} - {1'b0, position};
    assign out_letter = diff[5] ? 5'(diff + 6'(crs_pkg::ALPHA)) : 5'(diff);

    assign start_mod = (item.start_position >= 5'(crs_pkg::ALPHA))
                     ? 5'(item.start_position - 5'(crs_pkg::ALPHA))
                     : item.start_position;

    always_comb begin
        result        = '0;
        position_next = position;
        case (item.opcode)
            crs_pkg::OP_ADVANCE: begin
                result.carry  = crs_pkg::NOTCH[wheel][position];
                position_next = (position == 5'(crs_pkg::ALPHA - 1)) ? 5'd0 : position + 5'd1;
            end
            crs_pkg::OP_LOAD: begin
                position_next = start_mod;
            end
            default: begin
                result.letter_out = out_letter;
            end
        endcase
    end

endmodule

`default_nettype wire
